// ===== rtl/core/scm_pkg.sv =====
`timescale 1ns / 1ps

package scm_pkg;

    // field widths
    localparam int SAMPLE_W    = 12;
    localparam int PRODUCT_W   = 24;
    localparam int BUF_INDEX_W = 10;
    localparam int THRESH_W    = 12;
    localparam int TICK_W      = 10;
    localparam int PERIOD_W    = 35;
    localparam int FREQ_W      = 28;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;

    // sizing
    localparam int BUFFER_DEPTH = 1024;
    localparam int WIDX_W       = $clog2(BUFFER_DEPTH);
    localparam int COUNT_WIDTH  = 24;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(327);
    localparam logic [TICK_W-1:0]   TICK_RESET   = TICK_W'(10);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SIGN_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TICK_US        = CFG_INDEX_W'(1);

    // frequency numerator: 256e6 -> Q8 Hz from a period in microseconds
    localparam logic [FREQ_W-1:0] FREQ_NUM  = FREQ_W'(256000000);
    localparam int                DIV_STEPS = FREQ_W;
    localparam int                STEP_W    = $clog2(DIV_STEPS);

    // one classified sample travelling from front to back
    typedef struct packed {
        logic                   bank;
        logic [BUF_INDEX_W-1:0] index;
        logic [PRODUCT_W-1:0]   value;
        logic                   edge_hit;
        logic [COUNT_WIDTH-1:0] count;
        logic [SAMPLE_W-1:0]    peak;
    } job_t;

    // one finished result
    typedef struct packed {
        logic                   bank;
        logic [BUF_INDEX_W-1:0] index;
        logic [PRODUCT_W-1:0]   value;
        logic                   edge_hit;
        logic [PERIOD_W-1:0]    period;
        logic [FREQ_W-1:0]      freq;
        logic                   invalid;
        logic [SAMPLE_W-1:0]    peak;
    } result_t;

endpackage

// ===== rtl/core/scm_front.sv =====
`timescale 1ns / 1ps

module scm_front
    import scm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] abs_sample,
    input  logic [SAMPLE_W-1:0] sign_sample,
    input  logic [THRESH_W-1:0] sign_threshold,
    output job_t                job
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [WIDX_W-1:0]      WIDX_LAST = WIDX_W'(BUFFER_DEPTH - 1);

    logic [WIDX_W-1:0]      write_index_reg, write_index_next;
    logic                   bank_select_reg, bank_select_next;
    logic [COUNT_WIDTH-1:0] half_count_reg, half_count_next;
    logic [SAMPLE_W-1:0]    half_peak_reg, half_peak_next;
    logic                   last_sign_reg, last_sign_next;
    logic                   sign_known_reg, sign_known_next;

    logic sign;
    logic edge_hit;

    assign sign     = sign_sample > sign_threshold;
    // first sample only sets the polarity
    assign edge_hit = sign_known_reg && (last_sign_reg != sign);

    always_comb
    begin
        job.bank     = bank_select_reg;
        job.index    = BUF_INDEX_W'(write_index_reg);
        job.value    = PRODUCT_W'(abs_sample * sign_sample);
        job.edge_hit = edge_hit;
        job.count    = half_count_reg;
        job.peak     = half_peak_reg;
    end

    always_comb
    begin
        write_index_next = write_index_reg;
        bank_select_next = bank_select_reg;
        half_count_next  = half_count_reg;
        half_peak_next   = half_peak_reg;
        last_sign_next   = last_sign_reg;
        sign_known_next  = sign_known_reg;
        if (accept)
        begin
            if (write_index_reg == WIDX_LAST)
            begin
                write_index_next = '0;
                bank_select_next = ~bank_select_reg;
            end
            else
            begin
                write_index_next = write_index_reg + WIDX_W'(1);
            end
            sign_known_next = 1'b1;
            last_sign_next  = sign;
            if (edge_hit)
            begin
                half_count_next = '0;
                half_peak_next  = '0;
            end
            else
            begin
                if (abs_sample > half_peak_reg)
                    half_peak_next = abs_sample;
                if (half_count_reg != COUNT_MAX)
                    half_count_next = half_count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            bank_select_reg <= 1'b0;
            half_count_reg  <= '0;
            half_peak_reg   <= '0;
            last_sign_reg   <= 1'b0;
            sign_known_reg  <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            bank_select_reg <= bank_select_next;
            half_count_reg  <= half_count_next;
            half_peak_reg   <= half_peak_next;
            last_sign_reg   <= last_sign_next;
            sign_known_reg  <= sign_known_next;
        end
    end

endmodule

// ===== rtl/core/scm_queue.sv =====
`timescale 1ns / 1ps

module scm_queue
    import scm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               push, pop;

    assign wr_ready = fill_reg != CNT_FULL;
    assign rd_valid = fill_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + QCNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/scm_back.sv =====
`timescale 1ns / 1ps

module scm_back
    import scm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    input  logic [TICK_W-1:0] tick_us,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int HALF_W = PERIOD_W - 1;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    job_t                   job_reg, job_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PERIOD_W:0]      rem_reg, rem_next;
    logic [FREQ_W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   invalid_reg, invalid_next;

    logic                   slot_free;
    logic                   take;
    logic [PERIOD_W:0]      trial;
    logic [HALF_W-1:0]      half_period;
    logic [PERIOD_W-1:0]    product;

    assign slot_free = !res_valid_reg || res_ready;
    assign job_ready = (state_reg == B_IDLE) && slot_free;
    assign take      = job_valid && job_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // 2 * count * tick_us
    assign half_period = HALF_W'(job_reg.count) * HALF_W'(tick_us);
    assign product     = {half_period, 1'b0};
    // restoring step: bring down the next numerator bit
    assign trial   = {rem_reg[PERIOD_W-1:0], FREQ_NUM[step_reg]};

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        job_next       = job_reg;
        period_next    = period_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        invalid_next   = invalid_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    if (job.edge_hit)
                    begin
                        job_next   = job;
                        state_next = B_MUL;
                    end
                    else
                    begin
                        res_next.bank     = job.bank;
                        res_next.index    = job.index;
                        res_next.value    = job.value;
                        res_next.edge_hit = 1'b0;
                        res_next.period   = '0;
                        res_next.freq     = '0;
                        res_next.invalid  = 1'b0;
                        res_next.peak     = '0;
                        res_valid_next    = 1'b1;
                    end
                end
            end
            B_MUL:
            begin
                period_next  = product;
                rem_next     = '0;
                quo_next     = '0;
                step_next    = STEP_W'(DIV_STEPS - 1);
                invalid_next = (job_reg.count == '0) || (tick_us == '0);
                state_next   = ((job_reg.count == '0) || (tick_us == '0)) ? B_DONE : B_DIV;
            end
            B_DIV:
            begin
                if (trial >= {1'b0, period_reg})
                begin
                    rem_next = trial - {1'b0, period_reg};
                    quo_next = {quo_reg[FREQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[FREQ_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (slot_free)
                begin
                    res_next.bank     = job_reg.bank;
                    res_next.index    = job_reg.index;
                    res_next.value    = job_reg.value;
                    res_next.edge_hit = 1'b1;
                    res_next.period   = period_reg;
                    res_next.freq     = invalid_reg ? '0 : quo_reg;
                    res_next.invalid  = invalid_reg;
                    res_next.peak     = job_reg.peak;
                    res_valid_next    = 1'b1;
                    state_next        = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        job_reg     <= job_next;
        period_reg  <= period_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        invalid_reg <= invalid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== rtl/core/sign_crossing_frequency_meter_core.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------------
// input     | in        | in_valid / in_ready   | abs_sample, sign_sample
// result    | out       | out_valid / out_ready | buf_bank, buf_index, buf_value, edge_seen,
//           |           |                       | period_us, freq_q8, freq_invalid, peak_code
// config    | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// a sample with no polarity change is written to the queue, then to the output register
// and one can be taken every cycle while the output drains and no edge is in the back
// a sample that closes a half period goes in the back through the period multiply,
// the bit-serial frequency divide and the load of the output register
// the two-entry queue lets the front take up to two samples while the divider runs
// rst_n clears all control state and loads the register reset values

module sign_crossing_frequency_meter_core
    import scm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // sample transfer
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    abs_sample,
    input  logic [SAMPLE_W-1:0]    sign_sample,

    // result transfer
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   buf_bank,
    output logic [BUF_INDEX_W-1:0] buf_index,
    output logic [PRODUCT_W-1:0]   buf_value,
    output logic                   edge_seen,
    output logic [PERIOD_W-1:0]    period_us,
    output logic [FREQ_W-1:0]      freq_q8,
    output logic                   freq_invalid,
    output logic [SAMPLE_W-1:0]    peak_code
);

    // configuration registers
    logic [THRESH_W-1:0] sign_threshold_reg, sign_threshold_next;
    logic [TICK_W-1:0]   tick_us_reg, tick_us_next;

    // front to queue
    job_t    front_job;
    logic    q_wr_ready;
    logic    in_accept;

    // queue to back
    logic    q_rd_valid;
    logic    q_rd_ready;
    job_t    q_rd_data;

    result_t back_res;

    assign in_ready  = q_wr_ready;
    assign in_accept = in_valid && q_wr_ready;

    // register writes
    always_comb
    begin
        sign_threshold_next = sign_threshold_reg;
        tick_us_next        = tick_us_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_SIGN_THRESHOLD: sign_threshold_next = cfg_data[THRESH_W-1:0];
                CFG_IDX_TICK_US:        tick_us_next        = cfg_data[TICK_W-1:0];
                default:                sign_threshold_next = sign_threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_threshold_reg <= THRESH_RESET;
            tick_us_reg        <= TICK_RESET;
        end
        else
        begin
            sign_threshold_reg <= sign_threshold_next;
            tick_us_reg        <= tick_us_next;
        end
    end

    // polarity tracking, buffer position, product
    scm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .abs_sample     (abs_sample),
        .sign_sample    (sign_sample),
        .sign_threshold (sign_threshold_reg),
        .job            (front_job)
    );

    // decouples the front from the divider
    scm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (front_job),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // period multiply, frequency divide, output register
    scm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_rd_valid),
        .job_ready (q_rd_ready),
        .job       (q_rd_data),
        .tick_us   (tick_us_reg),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (back_res)
    );

    assign buf_bank     = back_res.bank;
    assign buf_index    = back_res.index;
    assign buf_value    = back_res.value;
    assign edge_seen    = back_res.edge_hit;
    assign period_us    = back_res.period;
    assign freq_q8      = back_res.freq;
    assign freq_invalid = back_res.invalid;
    assign peak_code    = back_res.peak;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// the sampler is driven from a backlog of samples that the stimulus block fills
// a software copy of the meter runs on every accepted sample transfer and queues
// the buffer write it should produce; the result side pops and compares field by field
// settings of the two registers change only while the meter is empty

module tb_top;
    import scm_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;     // lets the divider finish the last edge
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] sgn;
    } sample_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    abs_sample = '0;
    logic [SAMPLE_W-1:0]    sign_sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   buf_bank;
    logic [BUF_INDEX_W-1:0] buf_index;
    logic [PRODUCT_W-1:0]   buf_value;
    logic                   edge_seen;
    logic [PERIOD_W-1:0]    period_us;
    logic [FREQ_W-1:0]      freq_q8;
    logic                   freq_invalid;
    logic [SAMPLE_W-1:0]    peak_code;

    // software copy of the meter: registers and state
    logic [THRESH_W-1:0]    m_thresh;
    logic [TICK_W-1:0]      m_tick;
    logic [WIDX_W-1:0]      m_wr_index;
    logic                   m_bank;
    logic [COUNT_WIDTH-1:0] m_half_count;
    logic [SAMPLE_W-1:0]    m_half_peak;
    logic                   m_polarity;
    logic                   m_polarity_known;

    sample_t     sample_backlog[$];
    result_t     expected_buf_writes[$];
    result_t     want_write;
    sample_t     cur_sample;

    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned result_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned ready_gap = 0;
    int unsigned hold_left = 0;
    bit          idle_enable = 1'b1;
    bit          stall_request = 1'b0;
    logic        in_taken = 1'b0;

    sign_crossing_frequency_meter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .abs_sample   (abs_sample),
        .sign_sample  (sign_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .buf_bank     (buf_bank),
        .buf_index    (buf_index),
        .buf_value    (buf_value),
        .edge_seen    (edge_seen),
        .period_us    (period_us),
        .freq_q8      (freq_q8),
        .freq_invalid (freq_invalid),
        .peak_code    (peak_code)
    );

    always #5 clk = ~clk;

    // one tick of the meter: returns the buffer write and advances the state
    function automatic result_t advance_meter(input logic [SAMPLE_W-1:0] mag,
                                              input logic [SAMPLE_W-1:0] sgn);
        result_t     w;
        logic        polarity;
        logic [63:0] period;
        polarity = (sgn > m_thresh);
        w = '0;
        w.bank  = m_bank;
        w.index = m_wr_index;
        w.value = mag * sgn;
        // ping-pong wrap: last position flips the bank
        if (m_wr_index == WIDX_W'(BUFFER_DEPTH - 1)) begin
            m_wr_index = '0;
            m_bank     = ~m_bank;
        end
        else begin
            m_wr_index = m_wr_index + 1'b1;
        end
        // very first sample only fixes the polarity
        if (!m_polarity_known) begin
            m_polarity_known = 1'b1;
            m_polarity       = polarity;
        end
        if (polarity != m_polarity) begin
            // half period closed: full period is twice the half count
            period     = 64'(m_half_count) * 64'(m_tick) * 64'd2;
            w.edge_hit = 1'b1;
            w.period   = period[PERIOD_W-1:0];
            if (period == 64'd0)
                w.invalid = 1'b1;
            else
                w.freq = FREQ_W'(64'd256000000 / period);
            w.peak       = m_half_peak;
            m_half_peak  = '0;
            m_half_count = '0;
            m_polarity   = polarity;
        end
        else begin
            // same polarity: the sample counts and joins the peak
            if (mag > m_half_peak)
                m_half_peak = mag;
            if (m_half_count != '1)
                m_half_count = m_half_count + 1'b1;
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("write %0d %s: expected %0d, got %0d", result_count, name, want, got);
        end
    endtask

    // sample driver: holds the offer until the transfer, then picks the next
    // sample or a random gap
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 18) - 1;
                in_valid <= 1'b0;
            end
            else if (sample_backlog.size() > 0) begin
                cur_sample = sample_backlog.pop_front();
                in_valid    <= 1'b1;
                abs_sample  <= cur_sample.mag;
                sign_sample <= cur_sample.sgn;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure: random bursts plus one long hold on request
    always @(negedge clk) begin
        if (stall_request) begin
            hold_left     = LONG_HOLD;
            stall_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (ready_gap > 0) begin
            ready_gap--;
            out_ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: predicts on each sample transfer, checks each result transfer
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else begin
            in_taken <= in_valid && in_ready;
            if (rst_n && in_valid && in_ready) begin
                expected_buf_writes.push_back(advance_meter(abs_sample, sign_sample));
                accepted_total++;
            end
            if (rst_n && out_valid && out_ready) begin
                if (expected_buf_writes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("write %0d arrived with nothing predicted", result_count);
                end
                else begin
                    want_write = expected_buf_writes.pop_front();
                    check_field("buf_bank", want_write.bank, buf_bank);
                    check_field("buf_index", want_write.index, buf_index);
                    check_field("buf_value", want_write.value, buf_value);
                    check_field("edge_seen", want_write.edge_hit, edge_seen);
                    check_field("period_us", want_write.period, period_us);
                    check_field("freq_q8", want_write.freq, freq_q8);
                    check_field("freq_invalid", want_write.invalid, freq_invalid);
                    check_field("peak_code", want_write.peak, peak_code);
                end
                result_count++;
            end
        end
    end

    task automatic push_sample(input int unsigned mag, input int unsigned sgn);
        sample_t smp;
        smp.mag = SAMPLE_W'(mag);
        smp.sgn = SAMPLE_W'(sgn);
        sample_backlog.push_back(smp);
        queued_total++;
    endtask

    // a run of one polarity with random magnitudes, threshold kept below full scale
    task automatic push_run(input bit positive, input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            if (positive)
                push_sample($urandom_range(0, 4095), $urandom_range(m_thresh + 1, 4095));
            else
                push_sample($urandom_range(0, 4095), $urandom_range(0, m_thresh));
        end
    endtask

    // register write while the meter is empty; the copy follows at once
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_SIGN_THRESHOLD)
            m_thresh = data[THRESH_W-1:0];
        else
            m_tick = data[TICK_W-1:0];
    endtask

    // wait until every sample went through and every write came back
    task automatic settle();
        while (accepted_total != queued_total || expected_buf_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int unsigned phase_count;
        bit          positive;
        m_thresh         = THRESH_RESET;
        m_tick           = TICK_RESET;
        m_wr_index       = '0;
        m_bank           = 1'b0;
        m_half_count     = '0;
        m_half_peak      = '0;
        m_polarity       = 1'b0;
        m_polarity_known = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: first sample only sets polarity, then an edge of one tick,
        // an edge right after an edge, threshold equality, peak tracking
        push_sample(0, 0);
        push_sample(4095, 4095);
        push_sample(0, 0);
        push_sample(4095, 327);
        push_sample(1, 0);
        push_sample(2048, 328);
        push_sample(4095, 4095);
        push_sample(4094, 2000);
        push_sample(12, 3000);
        push_sample(0, 0);
        push_sample(2730, 1365);
        push_sample(1365, 2730);
        settle();

        // zero tick: every edge reports an undefined frequency
        write_register(CFG_IDX_TICK_US, CFG_DATA_W'(0));
        write_register(CFG_IDX_SIGN_THRESHOLD, CFG_DATA_W'(0));
        push_sample(5, 0);
        push_sample(5, 0);
        push_sample(7, 1);
        push_sample(9, 1);
        push_sample(3, 0);
        settle();

        // full-scale threshold: nothing is positive; then a tick of 1000 us
        write_register(CFG_IDX_SIGN_THRESHOLD, CFG_DATA_W'(4095));
        write_register(CFG_IDX_TICK_US, CFG_DATA_W'(1000));
        push_sample(4095, 4095);
        push_sample(100, 4095);
        push_sample(0, 0);
        settle();
        write_register(CFG_IDX_SIGN_THRESHOLD, CFG_DATA_W'(4094));
        push_sample(4095, 4095);
        push_sample(50, 4094);
        settle();

        // random phases: alternating polarity runs with random content, some noise
        for (int p = 0; p < 6; p++) begin
            write_register(CFG_IDX_SIGN_THRESHOLD, CFG_DATA_W'($urandom_range(0, 4094)));
            if (p == 0)
                write_register(CFG_IDX_TICK_US, CFG_DATA_W'(1));
            else if (p == 1)
                write_register(CFG_IDX_TICK_US, CFG_DATA_W'(1000));
            else
                write_register(CFG_IDX_TICK_US, CFG_DATA_W'($urandom_range(1, 1000)));
            // long result-side hold while samples keep coming
            if (p == 2)
                stall_request = 1'b1;
            // final stretch runs at full rate on both sides
            if (p == 5)
                idle_enable = 1'b0;
            phase_count = 0;
            positive    = $urandom_range(0, 1);
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
                    phase_count++;
                end
                else begin
                    int unsigned len;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                                       : $urandom_range(1, 30);
                    push_run(positive, len);
                    positive = ~positive;
                    phase_count += len;
                end
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/scm_pkg.sv
rtl/core/scm_front.sv
rtl/core/scm_queue.sv
rtl/core/scm_back.sv
rtl/core/sign_crossing_frequency_meter_core.sv
sim/tb_top.sv
